/* design/dqe_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the deque with erase by value.
// Used by dqe_cell and deque_with_erase_by_value_top; depends on nothing.
package dqe_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 16;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = $clog2(DEPTH);

  // Operation codes carried on the request
  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_POP_BACK   = 3'd1;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_ERASE      = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  // Command broadcast to every cell of the row
  typedef enum logic [2:0] {
    CMD_HOLD  = 3'd0,
    CMD_LOAD  = 3'd1,  // tail cell takes the value
    CMD_SHR   = 3'd2,  // every cell takes its front neighbor
    CMD_SHL   = 3'd3,  // every cell takes its back neighbor
    CMD_ERASE = 3'd4   // cells at and behind the first match take back neighbor
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t              cmd;
    logic [VALUE_WIDTH-1:0] value;
  } cell_ctrl_t;

endpackage

/* design/dqe_cell.sv */
`timescale 1ns / 1ps
// One storage cell of the deque row: holds one entry and moves it to or
// from its neighbors. Depends on dqe_pkg.
module dqe_cell
  import dqe_pkg::*;
(
  input  logic                   clk,
  input  cell_ctrl_t             ctrl,
  input  logic                   occupied,   // this slot lies below occupancy
  input  logic                   tail,       // this slot is the first free one
  input  logic [VALUE_WIDTH-1:0] front_data, // neighbor nearer the front
  input  logic [VALUE_WIDTH-1:0] back_data,  // neighbor nearer the back
  input  logic                   match_in,   // a match lies in front of this cell
  output logic                   match_out,
  output logic [VALUE_WIDTH-1:0] data
);

  logic hit;

  assign hit       = occupied && (data == ctrl.value);
  assign match_out = match_in || hit;

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_LOAD: begin
        if (tail) begin
          data <= ctrl.value;
        end
      end
      CMD_SHR: data <= front_data;
      CMD_SHL: data <= back_data;
      CMD_ERASE: begin
        // close the gap behind the first match
        if (match_out) begin
          data <= back_data;
        end
      end
      default: data <= data;
    endcase
  end

endmodule

/* design/deque_with_erase_by_value_top.sv */
`timescale 1ns / 1ps
// Top level of the deque with erase by value: request/result handshake,
// occupancy count and the row of dqe_cell. Depends on dqe_pkg and dqe_cell.
//
// Channel   Dir  Handshake           Payload
// request   in   s_tvalid/s_tready   s_tuser = operation, s_tdata = value
// result    out  m_tvalid/m_tready   m_tdata = removed_value, status, entry_count
//
// One request per cycle unless stalled; the result is registered on acceptance.
// Every cell compares and shifts in the same cycle, so erase is done at once.
// Synchronous active-high reset empties the queue and drops any pending result.
// A stalled result holds in the output register; a new request is taken in
// the cycle the pending result is taken.
module deque_with_erase_by_value_top
  import dqe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  input  logic [2:0]  s_tuser,   // [2:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [15:0] removed_value, [17:16] status,
                                 // [22:18] entry_count, [23] zero
);

  logic [CNT_W-1:0]       occupancy;
  logic [CNT_W-1:0]       occupancy_next;
  logic [VALUE_WIDTH-1:0] removed_value;
  logic [VALUE_WIDTH-1:0] removed_next;
  logic [1:0]             status;
  logic [1:0]             status_next;
  logic                   accept;
  logic                   full;
  logic                   empty;
  logic [IDX_W-1:0]       back_idx;
  logic [CNT_W-1:0]       occ_minus1;
  cell_ctrl_t             ctrl;

  logic [VALUE_WIDTH-1:0] cell_data  [DEPTH];
  logic                   cell_match [DEPTH];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = (occupancy == CNT_W'(DEPTH));
  assign empty    = (occupancy == '0);
  assign occ_minus1 = occupancy - CNT_W'(1);
  assign back_idx = occ_minus1[IDX_W-1:0];

  always_comb begin
    ctrl.value     = s_tdata[VALUE_WIDTH-1:0];
    ctrl.cmd       = CMD_HOLD;
    occupancy_next = occupancy;
    removed_next   = '0;
    status_next    = ST_OK;
    case (s_tuser)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.cmd       = (s_tuser == OP_PUSH_BACK) ? CMD_LOAD : CMD_SHR;
          occupancy_next = occupancy + CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          removed_next   = cell_data[back_idx];
          occupancy_next = occ_minus1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctrl.cmd       = CMD_SHL;
          removed_next   = cell_data[0];
          occupancy_next = occ_minus1;
        end
      end
      OP_ERASE: begin
        ctrl.cmd = CMD_ERASE;
        if (cell_match[DEPTH-1]) begin
          occupancy_next = occ_minus1;
        end else begin
          status_next = ST_NOMATCH;
        end
      end
      default: ctrl.cmd = CMD_HOLD;
    endcase
    // drop the command when no request is taken
    if (!accept) begin
      ctrl.cmd = CMD_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] front_d;
    logic [VALUE_WIDTH-1:0] back_d;
    logic                   m_in;

    if (i == 0) begin : g_first
      assign front_d = s_tdata[VALUE_WIDTH-1:0];
      assign m_in    = 1'b0;
    end else begin : g_mid
      assign front_d = cell_data[i-1];
      assign m_in    = cell_match[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign back_d = '0;
    end else begin : g_inner
      assign back_d = cell_data[i+1];
    end

    dqe_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occupancy > CNT_W'(i)),
      .tail       (occupancy == CNT_W'(i)),
      .front_data (front_d),
      .back_data  (back_d),
      .match_in   (m_in),
      .match_out  (cell_match[i]),
      .data       (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (accept) begin
        occupancy <= occupancy_next;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload: hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      removed_value <= removed_next;
      status        <= status_next;
    end
  end

  assign m_tdata = {1'b0, occupancy, status, removed_value};

endmodule
